@@ rtl/core/hid_keyboard_report_remapper_unit_assert.svh @@
// Assertion macros for the keyboard report remapper.
// No dependencies; ASSERT_OFF removes every check.
`ifndef HID_KEYBOARD_REPORT_REMAPPER_UNIT_ASSERT_SVH
`define HID_KEYBOARD_REPORT_REMAPPER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define HKRR_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("hkrr assertion failed");
`define HKRR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("hkrr assertion failed");
`else
`define HKRR_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons)
`define HKRR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

@@ rtl/core/hkrr_pkg.sv @@
// Shared types, constants and functions for the keyboard report remapper.
// No dependencies.
package hkrr_pkg;

	localparam int MAP_PAIRS      = 16;
	localparam int PAIRS_PER_WORD = 4;
	localparam int KEY_SLOTS      = 6;
	localparam int COUNT_W        = 5;

	localparam logic [7:0] FN_CODE    = 8'hFF;
	localparam logic [7:0] EJECT_CODE = 8'hFE;
	localparam logic [7:0] VIRT_FLOOR = 8'hF0;

	localparam logic [7:0] MOD_LCTRL = 8'h01;
	localparam logic [7:0] MOD_LALT  = 8'h04;
	localparam logic [7:0] MOD_LGUI  = 8'h08;
	localparam logic [7:0] MOD_RCTRL = 8'h10;
	localparam logic [7:0] MOD_RALT  = 8'h40;
	localparam logic [7:0] MOD_RGUI  = 8'h80;

	localparam int SPECIAL_FN_BIT    = 1;
	localparam int SPECIAL_EJECT_BIT = 0;

	typedef enum logic [2:0] {
		CFG_FN_LOCK,
		CFG_SWAP_ALT_CMD,
		CFG_MAP_PAIR_COUNT,
		CFG_MAP_WORD0,
		CFG_MAP_WORD1,
		CFG_MAP_WORD2,
		CFG_MAP_WORD3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] tgt;
		logic [7:0] src;
	} pair_t;

	typedef pair_t [MAP_PAIRS-1:0] map_t;

	typedef struct packed {
		logic               fn_lock;
		logic               swap_alt_cmd;
		logic [COUNT_W-1:0] pair_count;
		map_t               pairs;
	} cfg_t;

	typedef struct packed {
		logic [7:0]                modifier;
		logic [7:0]                reserved;
		logic [KEY_SLOTS-1:0][7:0] key;
	} report_t;

	typedef struct packed {
		report_t    rep;
		logic [7:0] ej_code;
		logic [7:0] fn_code;
		logic       fn_eff;
	} front_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} fn_hit_t;

	// Fixed Fn layer: arrows, Enter, F1-F12, P/B/S
	function automatic fn_hit_t fn_remap(input logic [7:0] k);
		fn_hit_t r;
		r.hit = 1'b1;
		unique case (k)
			8'h50: r.code = 8'h4A;
			8'h4F: r.code = 8'h4D;
			8'h52: r.code = 8'h4B;
			8'h51: r.code = 8'h4E;
			8'h28: r.code = 8'h49;
			8'h3A: r.code = 8'h68;
			8'h3B: r.code = 8'h69;
			8'h3C: r.code = 8'h6A;
			8'h3D: r.code = 8'h6B;
			8'h3E: r.code = 8'h6C;
			8'h3F: r.code = 8'h6D;
			8'h40: r.code = 8'h6E;
			8'h41: r.code = 8'h6F;
			8'h42: r.code = 8'h70;
			8'h43: r.code = 8'h71;
			8'h44: r.code = 8'h72;
			8'h45: r.code = 8'h73;
			8'h13: r.code = 8'h46;
			8'h05: r.code = 8'h48;
			8'h16: r.code = 8'h47;
			default: begin
				r.hit  = 1'b0;
				r.code = k;
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] swap_side(input logic [7:0] m, input logic [7:0] alt,
			input logic [7:0] gui);
		logic [7:0] r;
		if ((m & alt) != 8'h00) begin
			r = (m & ~alt) | gui;
		end else if ((m & gui) != 8'h00) begin
			r = (m & ~gui) | alt;
		end else begin
			r = m;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/hkrr_lookup.sv @@
// First-match search of one byte over the configured pair table.
// Depends on hkrr_pkg.
module hkrr_lookup import hkrr_pkg::*; (
	input  map_t               pairs,
	input  logic [COUNT_W-1:0] pair_count,
	input  logic [7:0]         key,
	output logic [7:0]         code
);

	// scan from the top so the lowest matching pair wins
	always_comb begin
		code = 8'h00;
		for (int p = MAP_PAIRS - 1; p >= 0; p--) begin
			if ((COUNT_W'(p) < pair_count) && (pairs[p].src == key)) begin
				code = pairs[p].tgt;
			end
		end
	end

endmodule

@@ rtl/core/hkrr_front.sv @@
// Front stage: Fn/Eject target lookup, Alt/GUI swap, Fn layer on key slot 0.
// Depends on hkrr_pkg and hkrr_lookup.
module hkrr_front import hkrr_pkg::*; (
	input  cfg_t       cfg,
	input  report_t    rep,
	input  logic [7:0] special,
	output front_t     res
);

	logic [7:0] fn_tgt;
	logic [7:0] ej_tgt;

	hkrr_lookup u_fn_lookup (
		.pairs      (cfg.pairs),
		.pair_count (cfg.pair_count),
		.key        (FN_CODE),
		.code       (fn_tgt)
	);

	hkrr_lookup u_ej_lookup (
		.pairs      (cfg.pairs),
		.pair_count (cfg.pair_count),
		.key        (EJECT_CODE),
		.code       (ej_tgt)
	);

	always_comb begin
		report_t r;
		fn_hit_t hit;
		logic    fn_pressed;
		logic    ej_pressed;
		logic    fn_present;
		logic    fn_eff;

		r          = rep;
		fn_pressed = special[SPECIAL_FN_BIT];
		ej_pressed = special[SPECIAL_EJECT_BIT];
		fn_present = (fn_tgt != 8'h00);
		fn_eff     = fn_present ? cfg.fn_lock : (fn_pressed | cfg.fn_lock);

		if (cfg.swap_alt_cmd) begin
			r.modifier = swap_side(swap_side(r.modifier, MOD_LALT, MOD_LGUI), MOD_RALT, MOD_RGUI);
		end

		hit = fn_remap(r.key[0]);
		if (fn_eff && ((r.key[0] != 8'h00) || (r.modifier != 8'h00))) begin
			priority if (hit.hit) begin
				r.key[0] = hit.code;
			end else if ((r.modifier & MOD_LCTRL) != 8'h00) begin
				r.modifier = (r.modifier & ~MOD_LCTRL) | MOD_RCTRL;
			end else if (fn_pressed && !fn_present) begin
				r = '0;
			end else begin
				// report passes unchanged
			end
		end

		res.rep     = r;
		res.ej_code = ej_pressed ? ej_tgt : 8'h00;
		res.fn_code = fn_pressed ? fn_tgt : 8'h00;
		res.fn_eff  = fn_eff;
	end

endmodule

@@ rtl/core/hkrr_slot_lane.sv @@
// One key slot lane: table remap of a real usage code.
// Depends on hkrr_pkg and hkrr_lookup.
module hkrr_slot_lane import hkrr_pkg::*; (
	input  map_t               pairs,
	input  logic [COUNT_W-1:0] pair_count,
	input  logic [7:0]         key,
	output logic [7:0]         key_out
);

	logic [7:0] tgt;

	hkrr_lookup u_lookup (
		.pairs      (pairs),
		.pair_count (pair_count),
		.key        (key),
		.code       (tgt)
	);

	assign key_out = ((key != 8'h00) && (key < VIRT_FLOOR) && (tgt != 8'h00)) ? tgt : key;

endmodule

@@ rtl/core/hkrr_merge.sv @@
// Merge of the lane results: Eject then Fn target into the lowest empty slot.
// Depends on hkrr_pkg.
module hkrr_merge import hkrr_pkg::*; (
	input  logic [KEY_SLOTS-1:0][7:0] key,
	input  logic [7:0]                ej_code,
	input  logic [7:0]                fn_code,
	output logic [KEY_SLOTS-1:0][7:0] key_out
);

	always_comb begin
		logic ej_done;
		logic fn_done;

		key_out = key;
		ej_done = (ej_code == 8'h00);
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (!ej_done && (key_out[i] == 8'h00)) begin
				key_out[i] = ej_code;
				ej_done    = 1'b1;
			end
		end
		fn_done = (fn_code == 8'h00);
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (!fn_done && (key_out[i] == 8'h00)) begin
				key_out[i] = fn_code;
				fn_done    = 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/hid_keyboard_report_remapper_unit.sv @@
// Top level of the keyboard report remapper: config registers, two-stage pipeline.
// Depends on hkrr_pkg, hkrr_front, hkrr_slot_lane, hkrr_merge and the assert header.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//   in      | in_valid / in_ready     | modifier_in, reserved_in, key0..5_in, special_in
//   out     | out_valid / out_ready   | modifier_out, reserved_out, key0..5_out,
//           |                         | special_out, fn_effective
//
// One report per cycle unless out_ready stalls; stages: front, then six slot lanes and merge.
// Reset clears all configuration registers and both pipeline valid flags.
// A stalled output holds stage 2; stage 1 keeps taking a transfer while it is empty.
// cfg_ready is always high.
`include "hid_keyboard_report_remapper_unit_assert.svh"
module hid_keyboard_report_remapper_unit import hkrr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  modifier_in,
	input  logic [7:0]  reserved_in,
	input  logic [7:0]  key0_in,
	input  logic [7:0]  key1_in,
	input  logic [7:0]  key2_in,
	input  logic [7:0]  key3_in,
	input  logic [7:0]  key4_in,
	input  logic [7:0]  key5_in,
	input  logic [7:0]  special_in,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  modifier_out,
	output logic [7:0]  reserved_out,
	output logic [7:0]  key0_out,
	output logic [7:0]  key1_out,
	output logic [7:0]  key2_out,
	output logic [7:0]  key3_out,
	output logic [7:0]  key4_out,
	output logic [7:0]  key5_out,
	output logic [7:0]  special_out,
	output logic        fn_effective
);

	cfg_t    cfg_q;
	report_t rep_in;
	front_t  front;
	front_t  data_s1;
	logic    valid_s1;
	report_t rep_s2;
	logic    fn_eff_s2;
	logic    valid_s2;
	logic    en_s1;
	logic    en_s2;

	logic [KEY_SLOTS-1:0][7:0] lane_key;
	logic [KEY_SLOTS-1:0][7:0] merged_key;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FN_LOCK:        cfg_q.fn_lock      <= cfg_data[0];
				CFG_SWAP_ALT_CMD:   cfg_q.swap_alt_cmd <= cfg_data[0];
				CFG_MAP_PAIR_COUNT: cfg_q.pair_count   <= cfg_data[COUNT_W-1:0];
				CFG_MAP_WORD0: cfg_q.pairs[0*PAIRS_PER_WORD +: PAIRS_PER_WORD] <= cfg_data;
				CFG_MAP_WORD1: cfg_q.pairs[1*PAIRS_PER_WORD +: PAIRS_PER_WORD] <= cfg_data;
				CFG_MAP_WORD2: cfg_q.pairs[2*PAIRS_PER_WORD +: PAIRS_PER_WORD] <= cfg_data;
				CFG_MAP_WORD3: cfg_q.pairs[3*PAIRS_PER_WORD +: PAIRS_PER_WORD] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rep_in.modifier = modifier_in;
	assign rep_in.reserved = reserved_in;
	assign rep_in.key      = {key5_in, key4_in, key3_in, key2_in, key1_in, key0_in};

	hkrr_front u_front (
		.cfg     (cfg_q),
		.rep     (rep_in),
		.special (special_in),
		.res     (front)
	);

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
		hkrr_slot_lane u_lane (
			.pairs      (cfg_q.pairs),
			.pair_count (cfg_q.pair_count),
			.key        (data_s1.rep.key[g]),
			.key_out    (lane_key[g])
		);
	end

	hkrr_merge u_merge (
		.key     (lane_key),
		.ej_code (data_s1.ej_code),
		.fn_code (data_s1.fn_code),
		.key_out (merged_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			data_s1 <= front;
		end
		if (en_s2 && valid_s1) begin
			rep_s2.modifier <= data_s1.rep.modifier;
			rep_s2.reserved <= data_s1.rep.reserved;
			rep_s2.key      <= merged_key;
			fn_eff_s2       <= data_s1.fn_eff;
		end
	end

	assign out_valid    = valid_s2;
	assign modifier_out = rep_s2.modifier;
	assign reserved_out = rep_s2.reserved;
	assign key0_out     = rep_s2.key[0];
	assign key1_out     = rep_s2.key[1];
	assign key2_out     = rep_s2.key[2];
	assign key3_out     = rep_s2.key[3];
	assign key4_out     = rep_s2.key[4];
	assign key5_out     = rep_s2.key[5];
	assign special_out  = 8'h00;
	assign fn_effective = fn_eff_s2;

	`HKRR_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	`HKRR_ASSERT_NEXT(a_s1_holds_on_stall, clk, arst_n, valid_s1 && !en_s2, valid_s1 && $stable(data_s1))
	`HKRR_ASSERT_IMPLIES(a_ready_when_s1_empty, clk, arst_n, !valid_s1, in_ready)

endmodule
